>>> hdl/wgsp_pkg.sv
// Shared types and constants for the window geometry string parser.
// Holds character codes, mask bit positions, the parser phase type and the result type.
// No dependencies.
package wgsp_pkg;

  // Default accumulator width
  localparam int VALUE_BITS_DEF = 32;

  // Width of every value on the result port
  localparam int OUT_BITS  = 32;
  localparam int MASK_BITS = 6;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'

  // Bit positions in the presence mask
  localparam int M_X    = 0;
  localparam int M_Y    = 1;
  localparam int M_W    = 2;
  localparam int M_H    = 3;
  localparam int M_XNEG = 4;
  localparam int M_YNEG = 5;

  // Resting phases of the parser between characters
  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_WIDTH,
    PH_HEIGHT,
    PH_XF,
    PH_YF,
    PH_ERROR
  } phase_t;

  // One parse result
  typedef struct packed {
    logic [MASK_BITS-1:0]       found_mask;
    logic signed [OUT_BITS-1:0] x_pos;
    logic signed [OUT_BITS-1:0] y_pos;
    logic [OUT_BITS-1:0]        width_val;
    logic [OUT_BITS-1:0]        height_val;
  } res_t;

endpackage

>>> hdl/wgsp_in_reg.sv
// Input register for the geometry parser: holds one character until the parser takes it.
// Depends on nothing but the handshake from the top level.
module wgsp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       take,
  output logic       ch_valid,
  output logic [7:0] ch
);

  logic       valid_r, valid_nxt;
  logic [7:0] ch_r;

  // Accept when empty or when the held character leaves this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the character on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

  assign ch_valid = valid_r;
  assign ch       = ch_r;

endmodule

>>> hdl/wgsp_fsm.sv
// Parser state machine and field datapath: one character per step.
// Uses wgsp_pkg for character codes, phase_t and res_t.
module wgsp_fsm #(
  parameter int VALUE_BITS = wgsp_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       ch,
  output wgsp_pkg::res_t   res
);

  localparam int OB = wgsp_pkg::OUT_BITS;
  localparam int MB = wgsp_pkg::MASK_BITS;

  wgsp_pkg::phase_t      phase_r, phase_nxt, phase_upd;
  logic [VALUE_BITS-1:0] accum_r, accum_nxt, accum_upd;
  logic                  neg_r, neg_nxt, neg_upd;
  logic                  has_r, has_nxt, has_upd;
  logic [MB-1:0]         mask_r, mask_nxt, mask_upd;
  logic [VALUE_BITS-1:0] x_r, x_nxt, x_upd;
  logic [VALUE_BITS-1:0] y_r, y_nxt, y_upd;
  logic [VALUE_BITS-1:0] w_r, w_nxt, w_upd;
  logic [VALUE_BITS-1:0] h_r, h_nxt, h_upd;

  logic                  is_zero, is_digit, is_sign, is_minus, is_lx, is_x, is_eq;
  logic                  in_field, field_stay, stay, fin_w, fin_f, err_end;
  logic [3:0]            dig;
  logic [VALUE_BITS-1:0] acc10, acc_neg, acc_h, acc_x, acc_y;
  wgsp_pkg::phase_t      lead_tgt;
  logic [OB-1:0]         x_out, y_out, w_out, h_out;

  // Decode the character
  always_comb begin
    is_zero  = (ch == wgsp_pkg::CH_NUL);
    is_digit = (ch inside {[wgsp_pkg::CH_0 : wgsp_pkg::CH_9]});
    is_sign  = (ch == wgsp_pkg::CH_PLUS) || (ch == wgsp_pkg::CH_MINUS);
    is_minus = (ch == wgsp_pkg::CH_MINUS);
    is_lx    = (ch == wgsp_pkg::CH_LX);
    is_x     = is_lx || (ch == wgsp_pkg::CH_UX);
    is_eq    = (ch == wgsp_pkg::CH_EQ);
    dig      = 4'(ch - wgsp_pkg::CH_0);
    in_field = (phase_r inside {wgsp_pkg::PH_HEIGHT, wgsp_pkg::PH_XF, wgsp_pkg::PH_YF});
    // A field keeps the character if it is its leading sign or a digit
    field_stay = (!has_r && is_sign) || is_digit;
  end

  // Next phase, before the end-of-string return to start
  always_comb begin
    if (is_sign) begin
      lead_tgt = wgsp_pkg::PH_XF;
    end else if (is_lx) begin
      lead_tgt = wgsp_pkg::PH_HEIGHT;
    end else if (is_digit) begin
      lead_tgt = wgsp_pkg::PH_WIDTH;
    end else begin
      lead_tgt = wgsp_pkg::PH_ERROR;
    end

    case (phase_r)
      wgsp_pkg::PH_START: begin
        phase_upd = is_eq ? wgsp_pkg::PH_LEAD : lead_tgt;
      end
      wgsp_pkg::PH_LEAD: begin
        phase_upd = lead_tgt;
      end
      wgsp_pkg::PH_WIDTH: begin
        if (is_digit) begin
          phase_upd = wgsp_pkg::PH_WIDTH;
        end else if (is_x) begin
          phase_upd = wgsp_pkg::PH_HEIGHT;
        end else if (is_sign) begin
          phase_upd = wgsp_pkg::PH_XF;
        end else begin
          phase_upd = wgsp_pkg::PH_ERROR;
        end
      end
      wgsp_pkg::PH_HEIGHT: begin
        if (field_stay) begin
          phase_upd = wgsp_pkg::PH_HEIGHT;
        end else if (has_r && is_sign) begin
          phase_upd = wgsp_pkg::PH_XF;
        end else begin
          phase_upd = wgsp_pkg::PH_ERROR;
        end
      end
      wgsp_pkg::PH_XF: begin
        if (field_stay) begin
          phase_upd = wgsp_pkg::PH_XF;
        end else if (has_r && is_sign) begin
          phase_upd = wgsp_pkg::PH_YF;
        end else begin
          phase_upd = wgsp_pkg::PH_ERROR;
        end
      end
      wgsp_pkg::PH_YF: begin
        phase_upd = field_stay ? wgsp_pkg::PH_YF : wgsp_pkg::PH_ERROR;
      end
      wgsp_pkg::PH_ERROR: begin
        phase_upd = wgsp_pkg::PH_ERROR;
      end
      default: begin
        phase_upd = wgsp_pkg::PH_ERROR;
      end
    endcase

    phase_nxt = phase_r;
    if (step) begin
      phase_nxt = is_zero ? wgsp_pkg::PH_START : phase_upd;
    end
  end

  // Field datapath and result values
  always_comb begin
    acc10   = (accum_r << 3) + (accum_r << 1) + {{(VALUE_BITS-4){1'b0}}, dig};
    acc_neg = ~accum_r + 1'b1;
    acc_h   = neg_r ? acc_neg : accum_r;
    acc_x   = (neg_r ^ mask_r[wgsp_pkg::M_XNEG]) ? acc_neg : accum_r;
    acc_y   = (neg_r ^ mask_r[wgsp_pkg::M_YNEG]) ? acc_neg : accum_r;

    stay  = (phase_upd == phase_r) && (in_field || (phase_r == wgsp_pkg::PH_WIDTH));
    fin_w = (phase_r == wgsp_pkg::PH_WIDTH) && !is_digit;
    fin_f = in_field && !field_stay && has_r;

    // Accumulate, hold or clear the current field
    if (stay && is_digit) begin
      accum_upd = acc10;
    end else if (stay) begin
      accum_upd = accum_r;
    end else if (phase_upd == wgsp_pkg::PH_WIDTH) begin
      accum_upd = {{(VALUE_BITS-4){1'b0}}, dig};
    end else begin
      accum_upd = '0;
    end
    has_upd = stay;
    neg_upd = stay && ((!has_r && is_sign) ? is_minus : neg_r);

    // Close finished fields
    mask_upd = mask_r;
    w_upd    = w_r;
    h_upd    = h_r;
    x_upd    = x_r;
    y_upd    = y_r;
    if (fin_w) begin
      w_upd = accum_r;
      mask_upd[wgsp_pkg::M_W] = 1'b1;
    end
    if (fin_f && (phase_r == wgsp_pkg::PH_HEIGHT)) begin
      h_upd = acc_h;
      mask_upd[wgsp_pkg::M_H] = 1'b1;
    end
    if (fin_f && (phase_r == wgsp_pkg::PH_XF)) begin
      x_upd = acc_x;
      mask_upd[wgsp_pkg::M_X] = 1'b1;
    end
    if (fin_f && (phase_r == wgsp_pkg::PH_YF)) begin
      y_upd = acc_y;
      mask_upd[wgsp_pkg::M_Y] = 1'b1;
    end
    // Direction sign on entry to the x or y field
    if ((phase_upd == wgsp_pkg::PH_XF) && (phase_r != wgsp_pkg::PH_XF) && is_minus) begin
      mask_upd[wgsp_pkg::M_XNEG] = 1'b1;
    end
    if ((phase_upd == wgsp_pkg::PH_YF) && (phase_r != wgsp_pkg::PH_YF) && is_minus) begin
      mask_upd[wgsp_pkg::M_YNEG] = 1'b1;
    end

    // End of string is an error after a bare '=', in an empty field, or after any error
    err_end = (phase_r == wgsp_pkg::PH_LEAD) || (phase_r == wgsp_pkg::PH_ERROR) ||
              (in_field && !has_r);

    // Hold, advance or return to reset values
    accum_nxt = accum_r;
    neg_nxt   = neg_r;
    has_nxt   = has_r;
    mask_nxt  = mask_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    if (step && is_zero) begin
      accum_nxt = '0;
      neg_nxt   = 1'b0;
      has_nxt   = 1'b0;
      mask_nxt  = '0;
      x_nxt     = '0;
      y_nxt     = '0;
      w_nxt     = '0;
      h_nxt     = '0;
    end else if (step) begin
      accum_nxt = accum_upd;
      neg_nxt   = neg_upd;
      has_nxt   = has_upd;
      mask_nxt  = mask_upd;
      x_nxt     = x_upd;
      y_nxt     = y_upd;
      w_nxt     = w_upd;
      h_nxt     = h_upd;
    end
  end

  // Fit values to the output width: truncate when wider, else sign-extend offsets, zero-extend sizes
  if (VALUE_BITS >= OB) begin : g_trunc
    assign x_out = x_upd[OB-1:0];
    assign y_out = y_upd[OB-1:0];
    assign w_out = w_upd[OB-1:0];
    assign h_out = h_upd[OB-1:0];
  end else begin : g_ext
    assign x_out = {{(OB-VALUE_BITS){x_upd[VALUE_BITS-1]}}, x_upd};
    assign y_out = {{(OB-VALUE_BITS){y_upd[VALUE_BITS-1]}}, y_upd};
    assign w_out = {{(OB-VALUE_BITS){1'b0}}, w_upd};
    assign h_out = {{(OB-VALUE_BITS){1'b0}}, h_upd};
  end

  // Result for an end character
  always_comb begin
    if (err_end) begin
      res = '0;
    end else begin
      res.found_mask = mask_upd;
      res.x_pos      = $signed(x_out);
      res.y_pos      = $signed(y_out);
      res.width_val  = w_out;
      res.height_val = h_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wgsp_pkg::PH_START;
      accum_r <= '0;
      neg_r   <= 1'b0;
      has_r   <= 1'b0;
      mask_r  <= '0;
      x_r     <= '0;
      y_r     <= '0;
      w_r     <= '0;
      h_r     <= '0;
    end else begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      neg_r   <= neg_nxt;
      has_r   <= has_nxt;
      mask_r  <= mask_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
    end
  end

endmodule

>>> hdl/wgsp_out_reg.sv
// Result register for the geometry parser: holds one result until the sink takes it.
// Uses wgsp_pkg for res_t.
module wgsp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  wgsp_pkg::res_t res_in,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output wgsp_pkg::res_t res_out
);

  logic           valid_r, valid_nxt;
  wgsp_pkg::res_t res_r;

  // Room for a new result when empty or when the held one transfers now
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

>>> hdl/window_geometry_string_parser.sv
// Top level of the geometry string parser: input register, parser, result register.
// Uses wgsp_pkg, wgsp_in_reg, wgsp_fsm and wgsp_out_reg.
//
//   channel  ports                                    direction  transfer
//   in       in_valid, in_ready, in_ch                sink       one character
//   out      out_valid, out_ready, out_found_mask,    source     one result per end
//            out_x_pos, out_y_pos, out_width_val,                character
//            out_height_val
//
// One character is taken per cycle unless an end character waits; it is held in the input
// register, then reaches the parser state and, for an end character, the result register.
// An end character waits in the input register only while the result register is full
// and out_ready is low; other characters never wait on the output side.
// Synchronous active-low reset empties both registers and returns the parser to the start
// of a string; after each end character the parser returns there on its own.
module window_geometry_string_parser #(
  parameter int VALUE_BITS = wgsp_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             in_ch,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [wgsp_pkg::MASK_BITS-1:0]         out_found_mask,
  output logic signed [wgsp_pkg::OUT_BITS-1:0]   out_x_pos,
  output logic signed [wgsp_pkg::OUT_BITS-1:0]   out_y_pos,
  output logic [wgsp_pkg::OUT_BITS-1:0]          out_width_val,
  output logic [wgsp_pkg::OUT_BITS-1:0]          out_height_val
);

  logic           ch_valid, take, is_end, out_free;
  logic [7:0]     ch;
  wgsp_pkg::res_t res, res_q;

  // Advance a character unless it ends a string and the result register is busy
  assign is_end = (ch == wgsp_pkg::CH_NUL);
  assign take   = ch_valid && (!is_end || out_free);

  wgsp_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .take     (take),
    .ch_valid (ch_valid),
    .ch       (ch)
  );

  wgsp_fsm #(
    .VALUE_BITS (VALUE_BITS)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (take),
    .ch    (ch),
    .res   (res)
  );

  wgsp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && is_end),
    .res_in    (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_found_mask = res_q.found_mask;
  assign out_x_pos      = res_q.x_pos;
  assign out_y_pos      = res_q.y_pos;
  assign out_width_val  = res_q.width_val;
  assign out_height_val = res_q.height_val;

endmodule
